[hw/rtl/dws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_pkg: shared types and codes for the searchable deque
// Item layouts for the command and result channels, operation and status
// codes, and the control word broadcast to every storage cell.
// ----------------------------------------------------------------------------
package dws_pkg;

	// operation codes
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_SEARCH     = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	// command item
	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
	} cmd_item_t;

	// result item
	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         match_position;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic [4:0]         count;
	} res_item_t;

	// control word seen by all cells in one cycle
	typedef struct packed {
		logic        push_front;
		logic        pop_front;
		logic        push_back;
		logic        search;
		logic        scan;
		logic [31:0] value;
	} cell_ctrl_t;

endpackage

[hw/rtl/deque_with_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search: bounded double-ended queue with value search
// A chain of cells keeps the elements in order from the front; front pushes
// and pops shift the chain, a back push writes one cell, a search compares
// in every cell, then walks the match flags to the front for the first hit.
// ----------------------------------------------------------------------------
//  channel | handshake             | item
//  --------+-----------------------+--------------------------------------
//  cmd     | cmd_valid / cmd_stall | operation, value
//  res     | res_valid / res_stall | status, match_position, front_value,
//          |                       | back_value, count
//
//  push and pop: one item per cycle while results are taken; the result is
//  registered from the response state. search: the result waits for the flag
//  scan, moving one cell per cycle up to the first hit or the last element.
//  reset clears the count, state and result valid; cell contents stay
//  undefined until written. a stalled result holds the next result back.
// ----------------------------------------------------------------------------
module deque_with_search #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  dws_pkg::cmd_item_t cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output dws_pkg::res_item_t res
);
	import dws_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = $clog2(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] pos_inc;
	logic [1:0]       status_q;
	logic [3:0]       match_q;
	logic             res_valid_q;
	res_item_t        res_q;

	logic             out_free;
	logic             accept;
	logic             full;
	logic             empty;
	logic             do_pf;
	logic             do_pb;
	logic             do_popf;
	logic             do_popb;
	logic             do_search;
	logic [1:0]       accept_status;
	logic             scan_hit;
	logic             scan_done;
	cell_ctrl_t       ctrl;

	logic [31:0]         cell_data [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;
	logic [CAPACITY-1:0] tail_vec;
	logic [31:0]         front_val;
	logic [31:0]         back_val;

	// handshake
	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = !((state_q == ST_IDLE) || ((state_q == ST_RESP) && out_free));
	assign accept    = cmd_valid && !cmd_stall;

	// operation decode
	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);
	assign do_pf     = accept && (cmd.operation == OP_PUSH_FRONT) && !full;
	assign do_pb     = accept && (cmd.operation == OP_PUSH_BACK) && !full;
	assign do_popf   = accept && (cmd.operation == OP_POP_FRONT) && !empty;
	assign do_popb   = accept && (cmd.operation == OP_POP_BACK) && !empty;
	assign do_search = accept && (cmd.operation == OP_SEARCH);

	always_comb begin
		case (cmd.operation)
			OP_PUSH_FRONT, OP_PUSH_BACK: accept_status = full ? STAT_FULL : STAT_OK;
			OP_POP_FRONT, OP_POP_BACK:   accept_status = empty ? STAT_EMPTY : STAT_OK;
			default:                     accept_status = STAT_OK;
		endcase
	end

	// next element count
	always_comb begin
		if (do_pf || do_pb) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_popf || do_popb) begin
			count_d = count_q - CNT_W'(1);
		end else begin
			count_d = count_q;
		end
	end

	// scan step: flag at the front cell, or end of the stored elements
	assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
	assign scan_hit  = hit_vec[0];
	assign scan_done = scan_hit || (pos_inc >= count_q);

	// broadcast control to the chain
	always_comb begin
		ctrl.push_front = do_pf;
		ctrl.pop_front  = do_popf;
		ctrl.push_back  = do_pb;
		ctrl.search     = do_search;
		ctrl.scan       = (state_q == ST_SCAN) && !scan_done;
		ctrl.value      = cmd.value;
	end

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] left_d;
		logic [31:0] right_d;
		logic        right_h;

		if (i == 0) begin : g_first
			assign left_d = cmd.value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
			assign right_h = 1'b0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
			assign right_h = hit_vec[i+1];
		end

		dws_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.count      (count_q),
			.count_next (count_d),
			.left_data  (left_d),
			.right_data (right_d),
			.right_hit  (right_h),
			.data       (cell_data[i]),
			.hit        (hit_vec[i]),
			.tail       (tail_vec[i])
		);
	end

	// front is cell 0, back is the cell that carries the tail mark
	always_comb begin
		back_val = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			back_val = back_val | (cell_data[k] & {32{tail_vec[k]}});
		end
		front_val = empty ? 32'd0 : cell_data[0];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			status_q    <= STAT_OK;
			match_q     <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			count_q <= count_d;

			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_SCAN: begin
					if (scan_hit) begin
						status_q <= STAT_OK;
						match_q  <= 4'(pos_q);
						state_q  <= ST_RESP;
					end else if (scan_done) begin
						status_q <= STAT_NOT_FOUND;
						match_q  <= '0;
						state_q  <= ST_RESP;
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				ST_RESP: begin
					if (out_free) begin
						res_valid_q          <= 1'b1;
						res_q.status         <= status_q;
						res_q.match_position <= match_q;
						res_q.front_value    <= front_val;
						res_q.back_value     <= back_val;
						res_q.count          <= 5'(count_q);
						state_q              <= ST_IDLE;
					end
				end
				default: begin
				end
			endcase

			// new item
			if (accept) begin
				status_q <= accept_status;
				match_q  <= '0;
				pos_q    <= '0;
				state_q  <= do_search ? ST_SCAN : ST_RESP;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("element count above capacity");

	a_tail_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tail_vec))
		else $error("more than one back marker");

	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (tail_vec == '0))
		else $error("back marker set on empty queue");

	a_scan_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> cmd_stall)
		else $error("item accepted during search scan");

	a_pop_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (count_q == '0) &&
		 ((cmd.operation == OP_POP_FRONT) || (cmd.operation == OP_POP_BACK)))
		|=> $stable(count_q))
		else $error("pop on empty queue changed the count");
`endif

endmodule

[hw/rtl/dws_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dws_cell: one storage cell of the deque chain
// Holds the element at one position from the front, shifts with its
// neighbors on front pushes and pops, compares for a search and hands its
// match flag toward the front during the scan.
// ----------------------------------------------------------------------------
module dws_cell #(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dws_pkg::cell_ctrl_t ctrl,
	input  logic [CNT_W-1:0]    count,
	input  logic [CNT_W-1:0]    count_next,
	input  logic [31:0]         left_data,
	input  logic [31:0]         right_data,
	input  logic                right_hit,
	output logic [31:0]         data,
	output logic                hit,
	output logic                tail
);
	import dws_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

	logic [31:0] data_q;
	logic        hit_q;
	logic        tail_q;

	// element storage, shifts right on push front and left on pop front
	always_ff @(posedge clk) begin
		if (ctrl.push_front) begin
			data_q <= left_data;
		end else if (ctrl.pop_front) begin
			data_q <= right_data;
		end else if (ctrl.push_back && (count == IDX_C)) begin
			data_q <= ctrl.value;
		end
	end

	// match flag: set by compare, then moves toward the front while scanning
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.search) begin
			hit_q <= (data_q == ctrl.value) && (IDX_C < count);
		end else if (ctrl.scan) begin
			hit_q <= right_hit;
		end
	end

	// marks the cell that holds the back element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
		end else begin
			tail_q <= (count_next == NEXT_C);
		end
	end

	assign data = data_q;
	assign hit  = hit_q;
	assign tail = tail_q;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the searchable deque
// A short table of directed items covers the empty and not-found cases,
// signed extremes, duplicates and the unused operation codes. It is followed
// by about a thousand random items in fill, search, drain and mixed runs.
// Results are checked against a ring-buffer mirror or fixed directed values
// while the sender idles and the receiver stalls at different rates.
// ----------------------------------------------------------------------------
module tb_top;
	import dws_pkg::*;

	localparam int CAPACITY      = 16;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int PHASE_ITEMS   = 250;
	localparam int STUCK_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;

	// operation codes the block leaves unused
	localparam logic [2:0] OP_UNUSED_5 = 3'd5;
	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;

	localparam logic [31:0] VAL_MIN = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [31:0] VAL_ONES = 32'hffff_ffff;

	typedef enum int {MODE_FILL, MODE_SEARCH, MODE_DRAIN, MODE_MIXED} mix_mode_t;

	typedef struct {
		cmd_item_t c;
		bit        typed;
		res_item_t r;
	} dir_entry_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res;

	// mirror of the queue contents
	logic [31:0] mirror_store [CAPACITY];
	int unsigned mirror_front = 0;
	int unsigned mirror_count = 0;

	res_item_t   awaited_results [$];
	dir_entry_t  directed_items [$];
	int          mismatch_count = 0;
	int          stuck_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	deque_with_search #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned ring_slot(input int unsigned offset);
		return (mirror_front + offset) % CAPACITY;
	endfunction

	// apply one operation to the mirror and return the result it yields
	function automatic res_item_t apply_deque_op(input cmd_item_t c);
		res_item_t r;
		bit        hit;
		r = '0;
		hit = 1'b0;
		case (c.operation)
			OP_PUSH_FRONT: begin
				if (mirror_count >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					mirror_front = (mirror_front + CAPACITY - 1) % CAPACITY;
					mirror_store[mirror_front] = c.value;
					mirror_count++;
				end
			end
			OP_PUSH_BACK: begin
				if (mirror_count >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					mirror_store[ring_slot(mirror_count)] = c.value;
					mirror_count++;
				end
			end
			OP_POP_FRONT: begin
				if (mirror_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					mirror_front = ring_slot(1);
					mirror_count--;
				end
			end
			OP_POP_BACK: begin
				if (mirror_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					mirror_count--;
				end
			end
			OP_SEARCH: begin
				r.status = STAT_NOT_FOUND;
				for (int unsigned i = 0; i < mirror_count; i++) begin
					if (!hit && mirror_store[ring_slot(i)] == c.value) begin
						hit = 1'b1;
						r.status = STAT_OK;
						r.match_position = 4'(i);
					end
				end
			end
			default: ;
		endcase
		if (mirror_count != 0) begin
			r.front_value = mirror_store[ring_slot(0)];
			r.back_value  = mirror_store[ring_slot(mirror_count - 1)];
		end
		r.count = 5'(mirror_count);
		return r;
	endfunction

	// values drawn from a small pool repeat often, which exercises first-match
	function automatic logic [31:0] pick_value();
		logic [31:0] pool [7];
		pool = '{32'd0, 32'd1, VAL_ONES, VAL_MIN, VAL_MAX, 32'd2, 32'd3};
		if ($urandom_range(99) < 40)
			return pool[$urandom_range(6)];
		return $urandom;
	endfunction

	// random item, biased by the current run mode
	function automatic cmd_item_t random_cmd(input mix_mode_t mode);
		cmd_item_t c;
		int        push_pct;
		int        pop_pct;
		int        pick;
		case (mode)
			MODE_FILL:   begin push_pct = 85; pop_pct = 5;  end
			MODE_DRAIN:  begin push_pct = 10; pop_pct = 80; end
			MODE_SEARCH: begin push_pct = 20; pop_pct = 15; end
			default:     begin push_pct = 40; pop_pct = 35; end
		endcase
		pick = $urandom_range(99);
		c.value = $urandom;
		if (pick < 3) begin
			c.operation = OP_UNUSED_5 + 3'($urandom_range(2));
		end else if (pick < 3 + push_pct) begin
			c.operation = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
			c.value = pick_value();
		end else if (pick < 3 + push_pct + pop_pct) begin
			c.operation = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
		end else begin
			c.operation = OP_SEARCH;
			if (mirror_count != 0 && $urandom_range(99) < 70)
				c.value = mirror_store[ring_slot($urandom_range(mirror_count - 1))];
			else
				c.value = pick_value();
		end
		return c;
	endfunction

	function automatic dir_entry_t dir_entry(input logic [2:0] op, input logic [31:0] val,
			input bit typed, input logic [1:0] st, input logic [3:0] pos,
			input logic [31:0] fr, input logic [31:0] bk, input logic [4:0] cnt);
		dir_entry_t d;
		d.c = '{operation: op, value: val};
		d.typed = typed;
		d.r = '{status: st, match_position: pos, front_value: fr, back_value: bk, count: cnt};
		return d;
	endfunction

	// present one item, wait for it to be taken, then record what it should yield
	task automatic send_cmd(input cmd_item_t c, input bit typed, input res_item_t typed_res);
		res_item_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			cmd <= '{operation: 3'($urandom_range(7)), value: $urandom};
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		predicted = apply_deque_op(c);
		awaited_results.push_back(typed ? typed_res : predicted);
	endtask

	// lower valid and hold off until every outstanding result is back
	task automatic drain_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// receiver stall
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// result checking
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result status %0d count %0d",
					$time, res.status, res.count);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (res.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, res.status);
					mismatch_count++;
				end
				if (res.match_position !== want.match_position) begin
					$display("%0t: match_position expected %0d got %0d",
						$time, want.match_position, res.match_position);
					mismatch_count++;
				end
				if (res.front_value !== want.front_value) begin
					$display("%0t: front_value expected %0d got %0d",
						$time, want.front_value, res.front_value);
					mismatch_count++;
				end
				if (res.back_value !== want.back_value) begin
					$display("%0t: back_value expected %0d got %0d",
						$time, want.back_value, res.back_value);
					mismatch_count++;
				end
				if (res.count !== want.count) begin
					$display("%0t: count expected %0d got %0d", $time, want.count, res.count);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// stimulus
	initial begin
		mix_mode_t mode;
		int        run_left;
		dir_entry_t d;

		for (int i = 0; i < CAPACITY; i++)
			mirror_store[i] = '0;

		// empty queue, extremes, unused codes, duplicates, back to empty
		directed_items.push_back(dir_entry(OP_POP_FRONT, 0, 1, STAT_EMPTY, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_POP_BACK, 0, 1, STAT_EMPTY, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_SEARCH, 0, 1, STAT_NOT_FOUND, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_PUSH_BACK, VAL_MAX, 1, STAT_OK, 0,
			VAL_MAX, VAL_MAX, 1));
		directed_items.push_back(dir_entry(OP_PUSH_FRONT, VAL_MIN, 1, STAT_OK, 0,
			VAL_MIN, VAL_MAX, 2));
		directed_items.push_back(dir_entry(OP_SEARCH, VAL_MIN, 1, STAT_OK, 0,
			VAL_MIN, VAL_MAX, 2));
		directed_items.push_back(dir_entry(OP_SEARCH, VAL_MAX, 1, STAT_OK, 1,
			VAL_MIN, VAL_MAX, 2));
		directed_items.push_back(dir_entry(OP_SEARCH, 0, 1, STAT_NOT_FOUND, 0,
			VAL_MIN, VAL_MAX, 2));
		directed_items.push_back(dir_entry(OP_UNUSED_5, VAL_ONES, 1, STAT_OK, 0,
			VAL_MIN, VAL_MAX, 2));
		directed_items.push_back(dir_entry(OP_UNUSED_6, VAL_ONES, 1, STAT_OK, 0,
			VAL_MIN, VAL_MAX, 2));
		directed_items.push_back(dir_entry(OP_UNUSED_7, VAL_MIN, 1, STAT_OK, 0,
			VAL_MIN, VAL_MAX, 2));
		directed_items.push_back(dir_entry(OP_PUSH_BACK, VAL_ONES, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_PUSH_FRONT, 0, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_PUSH_BACK, VAL_ONES, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_SEARCH, VAL_ONES, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_POP_FRONT, VAL_ONES, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_POP_BACK, 0, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_POP_BACK, 0, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_POP_FRONT, 0, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_POP_FRONT, 0, 1, STAT_OK, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_POP_BACK, 0, 1, STAT_EMPTY, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_PUSH_FRONT, 32'h5555_5555, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_PUSH_FRONT, 32'haaaa_aaaa, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_POP_FRONT, 0, 0, 0, 0, 0, 0, 0));
		directed_items.push_back(dir_entry(OP_POP_BACK, 0, 0, 0, 0, 0, 0, 0));

		// reset
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		foreach (directed_items[i]) begin
			d = directed_items[i];
			send_cmd(d.c, d.typed, d.r);
		end

		// random part in four phases, each entered once every result is back
		mode = MODE_MIXED;
		run_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_ITEMS == 0) begin
				drain_results();
				case (n / PHASE_ITEMS)
					0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
					2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
					default: begin send_idle_pct = 32; recv_stall_pct = 32; end
				endcase
			end
			if (run_left == 0) begin
				mode = mix_mode_t'((int'(mode) + 1) % 4);
				run_left = $urandom_range(20, 60);
			end
			run_left--;
			send_cmd(random_cmd(mode), 1'b0, '0);
		end

		// wind down
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[deque_with_search.f]
hw/rtl/dws_pkg.sv
hw/rtl/dws_cell.sv
hw/rtl/deque_with_search.sv
test/tb_top.sv
